[rtl/rqfp_pkg.sv]
// Shared types and constants for the ready queue (FIFO or priority order).
// Used by the queue cell, the top level and the port checker; no dependencies.
package rqfp_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [7:0] handle;
		logic [7:0] prio;
	} entry_t;

	// Search token that walks the cell row, one cell per cycle.
	typedef struct packed {
		logic   has;
		entry_t best;
		cnt_t   best_idx;
		entry_t last;
	} token_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cnt_t   fill;
		cnt_t   last_idx;
		logic   enq;
		entry_t new_ent;
		logic   shift;
		logic   replace;
		cnt_t   rep_idx;
		entry_t rep_ent;
	} cell_ctrl_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
		logic   dropped;
		logic   now_empty;
	} result_t;

endpackage

[rtl/rqfp_cell.sv]
// One slot of the ready queue: holds one entry and one stage of the search token.
// Depends on rqfp_pkg.
module rqfp_cell import rqfp_pkg::*; (
	input  logic       clk,
	input  cnt_t       idx,
	input  cell_ctrl_t ctrl,
	input  entry_t     nxt,
	output entry_t     ent,
	input  token_t     tok_in,
	output token_t     tok_out
);

	entry_t ent_q;
	token_t tok_q;
	token_t tok_d;
	logic   in_use;

	assign in_use = idx < ctrl.fill;

	always_ff @(posedge clk) begin
		if (ctrl.enq && idx == ctrl.fill) begin
			ent_q <= ctrl.new_ent;
		end else if (ctrl.shift) begin
			ent_q <= nxt;
		end else if (ctrl.replace && idx == ctrl.rep_idx) begin
			ent_q <= ctrl.rep_ent;
		end
	end

	// A strictly larger priority is needed to take over, so the lowest slot wins ties.
	always_comb begin
		tok_d = tok_in;
		if (in_use && (!tok_in.has || ent_q.prio > tok_in.best.prio)) begin
			tok_d.has      = 1'b1;
			tok_d.best     = ent_q;
			tok_d.best_idx = idx;
		end
		if (idx == ctrl.last_idx) begin
			tok_d.last = ent_q;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	assign ent     = ent_q;
	assign tok_out = tok_q;

endmodule

[rtl/ready_queue_fifo_or_priority_core.sv]
// Ready queue of task handles with FIFO or highest-priority dequeue.
// A row of rqfp_cell slots plus the controller and result register; uses rqfp_pkg.
//
// Usage:
//   Requests arrive on req_valid/req_stall with func, task_handle and task_priority;
//   a request transfers at a rising edge with req_valid high and req_stall low.
//   Every request yields exactly one result on res_valid/res_stall carrying
//   out_valid, out_handle, out_priority, dropped and now_empty.
//   Write fifo_mode (cfg_wr_en/cfg_wr_data) only while the queue is idle; unchecked.
// Timing:
//   An enqueue or a FIFO dequeue completes at once: its result is registered at the
//   transfer edge, and a new request can transfer in the very next cycle unless
//   res_stall holds it. A priority dequeue runs ST_SCAN, as a search token walks the
//   cell row one cell per cycle, and then moves the last entry into the freed slot.
// Reset:
//   arst_n clears state, fill count, mode (priority order) and result valid flag;
//   slot contents stay undefined until written.
// Back-pressure:
//   While res_stall holds a result, the result stays put and req_stall is raised.
module ready_queue_fifo_or_priority_core import rqfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       func,
	input  logic [7:0] task_handle,
	input  logic [7:0] task_priority,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       out_valid,
	output logic [7:0] out_handle,
	output logic [7:0] out_priority,
	output logic       dropped,
	output logic       now_empty
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t     state_q, state_d;
	cnt_t       fill_q, fill_d;
	idx_t       scan_q, scan_d;
	logic       fifo_mode_q;
	logic       res_valid_q;
	result_t    res_q, res_d;
	logic       res_load;
	logic       res_free;
	logic       req_xfer;
	logic       full, empty;
	cell_ctrl_t ctrl;
	entry_t     ent [QUEUE_DEPTH];
	token_t     tok [QUEUE_DEPTH+1];
	token_t     tok_fin;

	assign full     = fill_q == cnt_t'(QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign res_free = !res_valid_q || !res_stall;
	assign req_stall = (state_q != ST_IDLE) || !res_free;
	assign req_xfer = req_valid && !req_stall;
	assign tok[0]   = '0;
	assign tok_fin  = tok[QUEUE_DEPTH];

	always_comb begin
		ctrl.fill           = fill_q;
		ctrl.last_idx       = fill_q - cnt_t'(1);
		ctrl.enq            = req_xfer && func == FUNC_ENQ && !full;
		ctrl.new_ent.handle = task_handle;
		ctrl.new_ent.prio   = task_priority;
		ctrl.shift          = req_xfer && func == FUNC_DEQ && fifo_mode_q && !empty;
		ctrl.replace        = state_q == ST_DONE && res_free;
		ctrl.rep_idx        = tok_fin.best_idx;
		ctrl.rep_ent        = tok_fin.last;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		rqfp_cell u_cell (
			.clk    (clk),
			.idx    (cnt_t'(i)),
			.ctrl   (ctrl),
			.nxt    (nxt),
			.ent    (ent[i]),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		scan_d   = scan_q;
		res_load = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					res_load = 1'b1;
					if (func == FUNC_ENQ) begin
						res_d.dropped = full;
						if (!full) begin
							fill_d = fill_q + cnt_t'(1);
						end
					end else if (empty) begin
						res_d.now_empty = 1'b1;
					end else if (fifo_mode_q) begin
						res_d.valid     = 1'b1;
						res_d.ent       = ent[0];
						res_d.now_empty = fill_q == cnt_t'(1);
						fill_d          = fill_q - cnt_t'(1);
					end else begin
						res_load = 1'b0;
						scan_d   = '0;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				scan_d = scan_q + idx_t'(1);
				if (scan_q == idx_t'(QUEUE_DEPTH - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_load        = 1'b1;
					res_d.valid     = 1'b1;
					res_d.ent       = tok_fin.best;
					res_d.now_empty = fill_q == cnt_t'(1);
					fill_d          = fill_q - cnt_t'(1);
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_q      <= '0;
			fifo_mode_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			scan_q  <= scan_d;
			if (cfg_wr_en) begin
				fifo_mode_q <= cfg_wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_valid    = res_q.valid;
	assign out_handle   = res_q.ent.handle;
	assign out_priority = res_q.ent.prio;
	assign dropped      = res_q.dropped;
	assign now_empty    = res_q.now_empty;

endmodule

[rtl/rqfp_checker.sv]
// Port-level checks for the ready queue, attached to the top level by bind.
// Depends on rqfp_pkg and ready_queue_fifo_or_priority_core.
module rqfp_checker import rqfp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       func,
	input logic       res_valid,
	input logic       res_stall,
	input logic       out_valid,
	input logic [7:0] out_handle,
	input logic [7:0] out_priority,
	input logic       dropped,
	input logic       now_empty
);

	// A held result must stay offered until it transfers.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A result never both returns an entry and reports a refused enqueue.
	a_valid_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && dropped))
		else $error("result both valid and dropped");

	// Without a returned entry, handle and priority read as zero.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_handle == 8'd0 && out_priority == 8'd0)
		else $error("nonzero payload on result without entry");

	// An enqueue completes at once: its result follows in the next cycle.
	a_enq_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && func == FUNC_ENQ
			|=> res_valid && !out_valid && !now_empty)
		else $error("enqueue result missing or wrong");

endmodule

bind ready_queue_fifo_or_priority_core rqfp_checker u_rqfp_checker (.*);

[sim/tb_ready_queue_fifo_or_priority_core.sv]
// Self-checking testbench for the ready queue with FIFO or priority-order dequeue.
// Holds its own queue predictor in a small scoreboard class; depends on rqfp_pkg
// and ready_queue_fifo_or_priority_core only.
`timescale 1ns / 1ps

module tb_ready_queue_fifo_or_priority_core;
	import rqfp_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = QUEUE_DEPTH + 4;
	localparam int PRESSURE_AT     = 120;
	localparam int PRESSURE_CYCLES = 300;
	localparam int QUIET_FROM      = 300;
	localparam int QUIET_TO        = 420;

	// Predicts every result of the queue and checks the observed results in order.
	class ready_queue_scoreboard;
		entry_t      slot[QUEUE_DEPTH];
		int          fill;
		logic        fifo_mode;
		result_t     expected_q[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned prio_deqs;
		int unsigned fifo_deqs;
		int unsigned empty_deqs;
		int unsigned refused;

		function void set_mode(logic m);
			fifo_mode = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic f, logic [7:0] h, logic [7:0] p);
			result_t r;
			int      best;
			r = '0;
			requests++;
			if (f == FUNC_ENQ) begin
				if (fill < QUEUE_DEPTH) begin
					slot[fill].handle = h;
					slot[fill].prio   = p;
					fill++;
				end else begin
					r.dropped = 1'b1;
					refused++;
				end
			end else if (fill > 0) begin
				r.valid = 1'b1;
				if (fifo_mode) begin
					r.ent = slot[0];
					for (int i = 0; i < fill - 1; i++)
						slot[i] = slot[i + 1];
					fifo_deqs++;
				end else begin
					// Strictly greater keeps the lowest index on a tie.
					best = 0;
					for (int i = 1; i < fill; i++)
						if (slot[i].prio > slot[best].prio)
							best = i;
					r.ent      = slot[best];
					slot[best] = slot[fill - 1];
					prio_deqs++;
				end
				fill--;
			end else begin
				empty_deqs++;
			end
			r.now_empty = (fill == 0);
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic v, logic [7:0] h, logic [7:0] p, logic d, logic e);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no request outstanding (out_valid=%0b handle=%0d)",
					v, h);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("out_valid", 8'(want.valid), 8'(v));
			compare_field("out_handle", want.ent.handle, h);
			compare_field("out_priority", want.ent.prio, p);
			compare_field("dropped", 8'(want.dropped), 8'(d));
			compare_field("now_empty", 8'(want.now_empty), 8'(e));
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_wr_en     = 1'b0;
	logic       cfg_wr_data   = 1'b0;
	logic       req_valid     = 1'b0;
	logic       req_stall;
	logic       func          = FUNC_ENQ;
	logic [7:0] task_handle   = 8'd0;
	logic [7:0] task_priority = 8'd0;
	logic       res_valid;
	logic       res_stall     = 1'b0;
	logic       out_valid;
	logic [7:0] out_handle;
	logic [7:0] out_priority;
	logic       dropped;
	logic       now_empty;

	ready_queue_scoreboard sb = new;
	int  results_seen  = 0;
	int  hold_left     = 0;
	bit  pressure_done = 0;
	bit  sender_steady = 0;
	int  cycle_count   = 0;

	ready_queue_fifo_or_priority_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.task_handle  (task_handle),
		.task_priority(task_priority),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_valid    (out_valid),
		.out_handle   (out_handle),
		.out_priority (out_priority),
		.dropped      (dropped),
		.now_empty    (now_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, sb.pending());
			$display("tb_ready_queue_fifo_or_priority_core: FAIL");
			$finish;
		end
	end

	// Result side: checks each transfer, stalls at random outside a quiet span, and
	// once holds off long enough for the queue to back up into the request channel.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			sb.check_result(out_valid, out_handle, out_priority, dropped, now_empty);
			results_seen++;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (results_seen >= PRESSURE_AT && !pressure_done) begin
			pressure_done = 1;
			hold_left     = PRESSURE_CYCLES;
			res_stall     <= 1'b1;
		end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	task automatic send_request(logic f, logic [7:0] h, logic [7:0] p);
		if (!sender_steady && $urandom_range(0, 99) < 7) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		req_valid     <= 1'b1;
		func          <= f;
		task_handle   <= h;
		task_priority <= p;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(f, h, p);
	endtask

	// The mode only changes once every result is back and the block has settled.
	task automatic write_fifo_mode(logic m);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_mode(m);
	endtask

	// Enqueue share changes every 16 items so the queue swings between full and empty.
	task automatic run_random_phase(logic m, int count);
		int         enq_pct;
		logic [7:0] p;
		logic       f;
		write_fifo_mode(m);
		enq_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
			end
			// Half of the priorities come from a coarse set so that ties are common.
			if ($urandom_range(0, 1))
				p = 8'($urandom_range(0, 255));
			else
				p = 8'($urandom_range(0, 3) * 85);
			f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
			send_request(f, 8'($urandom_range(0, 255)), p);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part in priority order: empty dequeue, extremes, ties and a full queue.
		write_fifo_mode(1'b0);
		send_request(FUNC_DEQ, 8'hFF, 8'hFF);
		send_request(FUNC_ENQ, 8'h00, 8'h00);
		send_request(FUNC_ENQ, 8'hFF, 8'hFF);
		send_request(FUNC_ENQ, 8'h5A, 8'h80);
		send_request(FUNC_ENQ, 8'hA5, 8'hFF);
		for (int i = 4; i < QUEUE_DEPTH; i++)
			send_request(FUNC_ENQ, 8'(i * 17), 8'(i * 13));
		send_request(FUNC_ENQ, 8'h77, 8'hFF);
		send_request(FUNC_DEQ, 8'h00, 8'h00);
		send_request(FUNC_DEQ, 8'h00, 8'h00);

		// Three of the leftover entries then leave from the head of the queue, in slot order.
		write_fifo_mode(1'b1);
		send_request(FUNC_DEQ, 8'h00, 8'h00);
		send_request(FUNC_DEQ, 8'hFF, 8'hFF);
		send_request(FUNC_DEQ, 8'h00, 8'h00);

		for (int ph = 0; ph < 6; ph++) begin
			sender_steady = (ph == 2);
			run_random_phase(logic'(ph % 2), 100);
		end
		sender_steady = 0;
		req_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests in both modes: %0d priority and %0d FIFO dequeues,",
			sb.requests, sb.prio_deqs, sb.fifo_deqs);
		$display("%0d dequeues of an empty queue and %0d enqueues refused on a full queue.",
			sb.empty_deqs, sb.refused);
		if (sb.errors == 0) begin
			$display("tb_ready_queue_fifo_or_priority_core: PASS");
		end else begin
			$display("%0d mismatches found.", sb.errors);
			$display("tb_ready_queue_fifo_or_priority_core: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/rqfp_pkg.sv
rtl/rqfp_cell.sv
rtl/ready_queue_fifo_or_priority_core.sv
rtl/rqfp_checker.sv
sim/tb_ready_queue_fifo_or_priority_core.sv
